>>> rtl/bsa_pkg.sv
package bsa_pkg;

    localparam int HARMONIC_CAP    = 13;
    localparam int PHASE_BITS      = 16;
    localparam int SINE_TABLE_BITS = 10;

    localparam int RATE_W   = 18;
    localparam int FREQ_W   = 20;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 4;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

    // quotient of rate*8/freq is only needed exactly below CAP+2
    localparam int QUOT_LIM = HARMONIC_CAP + 2;
    localparam int QUOT_W   = $clog2(QUOT_LIM);
    localparam int STEP_W   = $clog2(QUOT_W);
    localparam int DIV_W    = FREQ_W + QUOT_W + 1;

    localparam int TERM_W = $clog2(HARMONIC_CAP);

    localparam int QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
    localparam int OFF_W       = SINE_TABLE_BITS - 1;
    localparam int SINE_W      = 15;
    localparam int COEF_W      = 29;
    localparam int PROD_W      = SINE_W + COEF_W;
    localparam int ACC_W       = 48;
    localparam int FRAC_SH     = 30;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          INV_PI_Q30  = 64'sd341782638;

    // (2n)*(2n+1) for Taylor term n
    localparam longint unsigned TAYLOR_DIV [1:8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef struct packed {
        logic [15:0]       phase;
        logic [FREQ_W-1:0] frequency;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [COUNT_W-1:0]         harmonics_used;
    } result_t;

    // front -> back job
    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic [TERM_W-1:0]     terms;
    } job_t;

    typedef logic [SINE_W-1:0] sine_rom_t [0:QUARTER_LEN];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t              rom;
        longint unsigned        x;
        longint unsigned        mag;
        longint                 sum;
        for (int i = 0; i <= QUARTER_LEN; i++)
        begin
            x = (HALF_PI_Q30 * 64'(i) + 64'(QUARTER_LEN / 2)) / 64'(QUARTER_LEN);
            mag = x;
            sum = longint'(x);
            for (int n = 1; n <= 8; n++)
            begin
                mag = (mag * x) >> 30;
                mag = (mag * x) >> 30;
                mag = mag / TAYLOR_DIV[n];
                if ((n % 2) == 1)
                    sum = sum - longint'(mag);
                else
                    sum = sum + longint'(mag);
            end
            if (sum < 0)
                sum = 0;
            sum = (sum + 64'sd16384) >>> 15;
            if (sum > 64'sd32767)
                sum = 64'sd32767;
            rom[i] = SINE_W'(sum);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> rtl/bsa_front.sv
module bsa_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  bsa_pkg::req_t                 req,
    input  logic                          cfg_valid,
    input  logic [bsa_pkg::RATE_W-1:0]    cfg_data,
    output logic                          job_push,
    input  logic                          job_full,
    output bsa_pkg::job_t                 job
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [bsa_pkg::RATE_W-1:0]     rate_reg;
    logic [bsa_pkg::PHASE_BITS-1:0] phase_reg;
    logic [bsa_pkg::FREQ_W-1:0]     freq_reg;
    logic [bsa_pkg::DIV_W-1:0]      rem_reg, rem_next;
    logic [bsa_pkg::QUOT_W-1:0]     quot_reg, quot_next;
    logic [bsa_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                           big_reg, big_next;

    logic                           accept;
    logic [bsa_pkg::DIV_W-1:0]      dividend;
    logic [bsa_pkg::DIV_W-1:0]      lim_prod;
    logic [bsa_pkg::DIV_W-1:0]      divisor;
    logic [bsa_pkg::TERM_W-1:0]     terms;

    assign accept   = push && !full;
    assign full     = (state_reg != F_IDLE);
    assign dividend = bsa_pkg::DIV_W'({rate_reg, 3'b000});
    assign lim_prod = bsa_pkg::DIV_W'(req.frequency) * bsa_pkg::DIV_W'(bsa_pkg::QUOT_LIM);
    assign divisor  = bsa_pkg::DIV_W'(freq_reg) << step_reg;

    always_comb
    begin
        if (big_reg)
            terms = bsa_pkg::TERM_W'(bsa_pkg::HARMONIC_CAP - 1);
        else if (quot_reg >= bsa_pkg::QUOT_W'(3))
            terms = bsa_pkg::TERM_W'(quot_reg - bsa_pkg::QUOT_W'(2));
        else
            terms = '0;
    end

    assign job_push    = (state_reg == F_PUSH) && !job_full;
    assign job.phase   = phase_reg;
    assign job.terms   = terms;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;
        big_next   = big_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    rem_next  = dividend;
                    quot_next = '0;
                    step_next = bsa_pkg::STEP_W'(bsa_pkg::QUOT_W - 1);
                    big_next  = 1'b0;
                    if (req.frequency == '0)
                    begin
                        state_next = F_PUSH;
                    end
                    else if (dividend >= lim_prod)
                    begin
                        big_next   = 1'b1;
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_reg >= divisor)
                begin
                    rem_next            = rem_reg - divisor;
                    quot_next[step_reg] = 1'b1;
                end
                if (step_reg == '0)
                    state_next = F_PUSH;
                else
                    step_next = step_reg - bsa_pkg::STEP_W'(1);
            end
            F_PUSH:
            begin
                if (!job_full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            rate_reg  <= bsa_pkg::RATE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                rate_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            phase_reg <= req.phase[bsa_pkg::PHASE_BITS-1:0];
            freq_reg  <= req.frequency;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
        big_reg  <= big_next;
    end

endmodule

>>> rtl/bsa_queue.sv
module bsa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    output logic           full,
    input  bsa_pkg::job_t  wr_data,
    input  logic           rd_en,
    output logic           empty,
    output bsa_pkg::job_t  rd_data
);

    bsa_pkg::job_t slot_reg [0:1];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 2'd1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> rtl/bsa_back.sv
module bsa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_empty,
    output logic               job_pop,
    input  bsa_pkg::job_t      job,
    output logic               empty,
    input  logic               pop,
    output bsa_pkg::result_t   result
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_RUN  = 4'b0010,
        B_WAIT = 4'b0100,
        B_FIN  = 4'b1000
    } back_state_t;

    localparam int STB = bsa_pkg::SINE_TABLE_BITS;
    localparam int PB  = bsa_pkg::PHASE_BITS;

    back_state_t state_reg, state_next;

    logic [PB-1:0]                       phase_reg;
    logic [PB-1:0]                       pk_reg;
    logic [bsa_pkg::TERM_W-1:0]          k_reg;
    logic [bsa_pkg::TERM_W-1:0]          terms_reg;
    logic signed [bsa_pkg::ACC_W-1:0]    acc_reg;

    logic                                s1_valid_reg;
    logic [bsa_pkg::SINE_W-1:0]          s1_sine_reg;
    logic [bsa_pkg::COEF_W-1:0]          s1_coef_reg;
    logic                                s1_neg_reg;
    logic                                s2_valid_reg;
    logic [bsa_pkg::PROD_W-1:0]          s2_prod_reg;
    logic                                s2_neg_reg;

    logic                                out_valid_reg;
    bsa_pkg::result_t                    out_reg;

    logic [STB-1:0]                      idx;
    logic [1:0]                          quad;
    logic [bsa_pkg::OFF_W-1:0]           off_raw;
    logic [bsa_pkg::OFF_W-1:0]           off;
    logic [bsa_pkg::COEF_W-1:0]          coef_tab [0:(1 << bsa_pkg::TERM_W) - 1];
    logic                                issue;
    logic                                load_out;
    logic signed [bsa_pkg::ACC_W-1:0]    rounded;
    logic signed [bsa_pkg::SAMPLE_W-1:0] sat_sample;

    // 1/(pi*k) in Q0.30, entry k; unused entries zero
    for (genvar g = 0; g < (1 << bsa_pkg::TERM_W); g++)
    begin : g_coef
        if (g >= 1 && g < bsa_pkg::HARMONIC_CAP)
        begin : g_used
            localparam longint COEF_K = (bsa_pkg::INV_PI_Q30 + g / 2) / g;
            assign coef_tab[g] = bsa_pkg::COEF_W'(COEF_K);
        end
        else
        begin : g_zero
            assign coef_tab[g] = '0;
        end
    end

    // top table bits of the harmonic phase, then quarter-wave folding
    assign idx     = STB'({pk_reg, {STB{1'b0}}} >> PB);
    assign quad    = idx[STB-1 -: 2];
    assign off_raw = {1'b0, idx[STB-3:0]};
    assign off     = quad[0] ? bsa_pkg::OFF_W'(bsa_pkg::QUARTER_LEN) - off_raw : off_raw;

    assign issue    = (state_reg == B_RUN);
    assign job_pop  = (state_reg == B_IDLE) && !job_empty;
    assign load_out = (state_reg == B_FIN) && (!out_valid_reg || pop);

    assign rounded = (acc_reg + (bsa_pkg::ACC_W'(1) <<< (bsa_pkg::FRAC_SH - 1)))
                     >>> bsa_pkg::FRAC_SH;

    always_comb
    begin
        if (rounded > bsa_pkg::ACC_W'(32767))
            sat_sample = 16'sh7fff;
        else if (rounded < -bsa_pkg::ACC_W'(32768))
            sat_sample = 16'sh8000;
        else
            sat_sample = bsa_pkg::SAMPLE_W'(rounded);
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                    state_next = (job.terms == '0) ? B_FIN : B_RUN;
            end
            B_RUN:
            begin
                if (k_reg == terms_reg)
                    state_next = B_WAIT;
            end
            B_WAIT:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                    state_next = B_FIN;
            end
            B_FIN:
            begin
                if (load_out)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            phase_reg <= job.phase;
            pk_reg    <= job.phase;
            k_reg     <= bsa_pkg::TERM_W'(1);
            terms_reg <= job.terms;
        end
        else if (issue)
        begin
            pk_reg <= pk_reg + phase_reg;
            k_reg  <= k_reg + bsa_pkg::TERM_W'(1);
        end

        // lookup stage
        s1_sine_reg <= bsa_pkg::SINE_ROM[off];
        s1_coef_reg <= coef_tab[k_reg];
        s1_neg_reg  <= quad[1] ^ k_reg[0];

        // multiply stage
        s2_prod_reg <= bsa_pkg::PROD_W'(s1_sine_reg) * bsa_pkg::PROD_W'(s1_coef_reg);
        s2_neg_reg  <= s1_neg_reg;

        // accumulate stage
        if (job_pop)
            acc_reg <= '0;
        else if (s2_valid_reg)
        begin
            if (s2_neg_reg)
                acc_reg <= acc_reg - bsa_pkg::ACC_W'(s2_prod_reg);
            else
                acc_reg <= acc_reg + bsa_pkg::ACC_W'(s2_prod_reg);
        end

        if (load_out)
        begin
            out_reg.sample         <= sat_sample;
            out_reg.harmonics_used <= bsa_pkg::COUNT_W'(terms_reg);
        end
    end

endmodule

>>> rtl/bandlimited_saw_additive_unit.sv
// Band-limited sawtooth oscillator: each request (phase, frequency in 1/16 Hz)
// yields one Q1.15 sample summing up to 12 sine harmonics weighted 1/(pi*k),
// plus the number of harmonics used. The front accepts a request, derives the
// harmonic count from sample_rate_hz*8/frequency with a one-bit-per-cycle
// divider and hands the job to a two-entry queue, taking no new request
// until the job is queued. The back evaluates one harmonic per cycle through
// a lookup, multiply and accumulate pipeline. A finished sample waits in the
// output register while the next request is accepted.
// cfg_ready is always high; write sample_rate_hz only while the unit is idle.
module bandlimited_saw_additive_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  bsa_pkg::req_t                 req,
    output logic                          empty,
    input  logic                          pop,
    output bsa_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsa_pkg::RATE_W-1:0]    cfg_data
);

    logic          job_push;
    logic          job_full;
    logic          job_pop;
    logic          job_empty;
    bsa_pkg::job_t job_in;
    bsa_pkg::job_t job_out;

    assign cfg_ready = 1'b1;

    bsa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .job_push  (job_push),
        .job_full  (job_full),
        .job       (job_in)
    );

    bsa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .full    (job_full),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .empty   (job_empty),
        .rd_data (job_out)
    );

    bsa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .job       (job_out),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> test/tb_bandlimited_saw_additive_unit.sv
`timescale 1ns / 1ps

module tb_bandlimited_saw_additive_unit;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         push = 1'b0;
    logic                         full;
    bsa_pkg::req_t                req = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    bsa_pkg::result_t             result;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [bsa_pkg::RATE_W-1:0]   cfg_data = '0;

    bandlimited_saw_additive_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // testbench copy of the rate register and of the quarter-wave sine table
    logic [bsa_pkg::RATE_W-1:0]   rate_hz = bsa_pkg::RATE_RESET;
    int                           sine_quarter [0:bsa_pkg::QUARTER_LEN];

    bsa_pkg::req_t                pending_reqs [$];
    bsa_pkg::result_t             expected_samples [$];

    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  recv_hold_left = 0;
    int                  err_cnt = 0;
    int                  n_accepted = 0;
    int                  n_checked = 0;
    int                  n_rates = 1;
    int                  cycles = 0;
    int                  terms_seen [0:15];

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        longint unsigned x;
        longint unsigned mag;
        longint          acc;
        for (int i = 0; i <= bsa_pkg::QUARTER_LEN; i++)
        begin
            x = (bsa_pkg::HALF_PI_Q30 * longint'(i) + longint'(bsa_pkg::QUARTER_LEN / 2))
                / longint'(bsa_pkg::QUARTER_LEN);
            mag = x;
            acc = longint'(x);
            for (int n = 1; n <= 8; n++)
            begin
                mag = (mag * x) >> 30;
                mag = (mag * x) >> 30;
                mag = mag / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - longint'(mag);
                else
                    acc = acc + longint'(mag);
            end
            if (acc < 0)
                acc = 0;
            acc = (acc + 16384) >>> 15;
            if (acc > 32767)
                acc = 32767;
            sine_quarter[i] = int'(acc);
        end
        for (int i = 0; i < 16; i++)
            terms_seen[i] = 0;
    end

    // expected sample for one request at the given rate
    function automatic bsa_pkg::result_t saw_sample(input bsa_pkg::req_t r,
                                                    input logic [bsa_pkg::RATE_W-1:0] rate);
        bsa_pkg::result_t                          res;
        longint                                    acc;
        longint                                    coef;
        longint                                    s;
        int                                        lim;
        int                                        terms;
        int                                        off;
        int                                        v;
        logic [bsa_pkg::PHASE_BITS-1:0]            pk;
        logic [bsa_pkg::SINE_TABLE_BITS-1:0]       idx;
        acc = 0;
        terms = 0;
        if (r.frequency != '0)
        begin
            lim = int'((longint'(rate) * 8) / longint'(r.frequency)) - 1;
            if (lim > bsa_pkg::HARMONIC_CAP)
                lim = bsa_pkg::HARMONIC_CAP;
            terms = (lim > 1) ? lim - 1 : 0;
        end
        for (int k = 1; k <= terms; k++)
        begin
            pk = bsa_pkg::PHASE_BITS'(k * r.phase[bsa_pkg::PHASE_BITS-1:0]);
            idx = bsa_pkg::SINE_TABLE_BITS'(pk >> (bsa_pkg::PHASE_BITS
                                                   - bsa_pkg::SINE_TABLE_BITS));
            off = int'(idx[bsa_pkg::SINE_TABLE_BITS-3:0]);
            if (idx[bsa_pkg::SINE_TABLE_BITS-2])
                off = bsa_pkg::QUARTER_LEN - off;
            v = sine_quarter[off];
            if (idx[bsa_pkg::SINE_TABLE_BITS-1])
                v = -v;
            coef = (bsa_pkg::INV_PI_Q30 + longint'(k / 2)) / longint'(k);
            if (k % 2 == 1)
                acc = acc - longint'(v) * coef;
            else
                acc = acc + longint'(v) * coef;
        end
        s = (acc + (64'sd1 <<< 29)) >>> 30;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        res.sample = bsa_pkg::SAMPLE_W'(s);
        res.harmonics_used = bsa_pkg::COUNT_W'(terms);
        return res;
    endfunction

    // half the time a frequency that lands on each harmonic count, the rest anywhere
    function automatic logic [bsa_pkg::FREQ_W-1:0] pick_freq(
        input logic [bsa_pkg::RATE_W-1:0] rate);
        longint base;
        int     q;
        case ($urandom_range(3))
            0: return bsa_pkg::FREQ_W'($urandom);
            1: return bsa_pkg::FREQ_W'($urandom_range(1, 4000));
            default:
            begin
                q = $urandom_range(2, 16);
                base = (longint'(rate) * 8) / q;
                return bsa_pkg::FREQ_W'(base + $urandom_range(2) - 1);
            end
        endcase
    endfunction

    // driver: offers pending requests, holds one until it is taken
    always @(posedge clk)
    begin
        bsa_pkg::result_t exp_res;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                exp_res = saw_sample(req, rate_hz);
                expected_samples.push_back(exp_res);
                terms_seen[exp_res.harmonics_used]++;
                n_accepted++;
            end
            if (!push || !full)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    req  <= pending_reqs.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each popped result against the oldest expectation
    always @(posedge clk)
    begin
        bsa_pkg::result_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                n_checked++;
                if (expected_samples.size() == 0)
                begin
                    $error("unexpected result: sample %0d harmonics_used %0d",
                           result.sample, result.harmonics_used);
                    err_cnt++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (result.sample !== want.sample)
                    begin
                        $error("sample: expected %0d, got %0d", want.sample, result.sample);
                        err_cnt++;
                    end
                    if (result.harmonics_used !== want.harmonics_used)
                    begin
                        $error("harmonics_used: expected %0d, got %0d",
                               want.harmonics_used, result.harmonics_used);
                        err_cnt++;
                    end
                end
            end
            pop <= (recv_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (recv_hold_left > 0)
            recv_hold_left <= recv_hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d requests still expected",
                     cycles, expected_samples.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic add_req(input logic [15:0] ph, input logic [bsa_pkg::FREQ_W-1:0] fr);
        bsa_pkg::req_t r;
        r.phase = ph;
        r.frequency = fr;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            add_req(16'($urandom), pick_freq(rate_hz));
    endtask

    // sender idle until every request has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || push || expected_samples.size() != 0);
    endtask

    task automatic write_rate(input logic [bsa_pkg::RATE_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate_hz = v;
    endtask

    task automatic next_phase(input logic [bsa_pkg::RATE_W-1:0] rate, input int sp,
                              input int rp, input int n);
        wait_drained();
        write_rate(rate);
        n_rates++;
        @(negedge clk);
        send_idle_pct  = sp;
        recv_stall_pct = rp;
        queue_random(n);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset rate, directed corners
        add_req(16'h0000, 20'd1);
        add_req(16'hFFFF, 20'd1);
        add_req(16'h0100, 20'd1);
        add_req(16'hFF00, 20'd1);
        add_req(16'h4000, 20'd1);
        add_req(16'h8000, 20'd1);
        add_req(16'hC000, 20'd1);
        add_req(16'h2000, 20'd1);
        add_req(16'h0400, 20'd7040);
        add_req(16'hFC00, 20'd7040);
        add_req(16'h1234, 20'd0);         // zero frequency
        add_req(16'hFFFF, 20'd0);
        add_req(16'h5555, 20'hFFFFF);     // negative limit
        add_req(16'hAAAA, 20'd192000);    // limit of one
        add_req(16'h3000, 20'd128000);    // limit of two, one term
        add_req(16'h3000, 20'd127999);
        add_req(16'h0040, 20'd27428);     // limit at the cap
        add_req(16'h0040, 20'd25600);
        add_req(16'h0001, 20'd3520);
        add_req(16'hFFFE, 20'h80000);
        add_req(16'h7FFF, 20'd54857);
        add_req(16'h8001, 20'd42666);
        queue_random(150);

        next_phase(bsa_pkg::RATE_W'(8000), 65, 0, 200);

        // receiver held off while the sender keeps offering
        wait_drained();
        recv_hold_left = HOLD_CYCLES;
        next_phase(bsa_pkg::RATE_W'(192000), 0, 65, 200);

        next_phase(bsa_pkg::RATE_W'(18'h3FFFF), 32, 32, 150);

        next_phase(bsa_pkg::RATE_W'($urandom_range(8000, 192000)), 0, 0, 150);
        wait_drained();
        queue_random(150);

        next_phase(bsa_pkg::RATE_W'(0), 32, 32, 60);
        next_phase(bsa_pkg::RATE_W'(44100), 0, 0, 150);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests over %0d rate settings, %0d results checked",
                 n_accepted, n_rates, n_checked);
        $display("Harmonic counts: 0:%0d 1:%0d 6:%0d 11:%0d 12:%0d",
                 terms_seen[0], terms_seen[1], terms_seen[6], terms_seen[11], terms_seen[12]);
        if (err_cnt == 0 && expected_samples.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
